/* rtl/frl_pkg.sv */
// ----------------------------------------------------------------------------
// frl_pkg
// Shared types and constants for the flash page record log.
// ----------------------------------------------------------------------------
package frl_pkg;

  localparam int OP_W    = 2;
  localparam int CNT_W   = 11;
  localparam int POS_W   = 10;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 11;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 24;
  localparam int WORD_W  = 16;

  localparam logic [OP_W-1:0] OP_APPEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR_LAST  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_ALL   = 2'd2;
  localparam logic [OP_W-1:0] OP_READ      = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERSIZE = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_FEW  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_MARK  = 2'd3;

  localparam logic [BYTE_W-1:0] REC_MARKER = 8'h5A;

  // controller -> datapath
  typedef struct packed {
    logic cap;        // latch input word
    logic decide;     // evaluate the item, do append write
    logic clr_step;   // zero one word of the clear range
    logic chk_first;  // check marker of first record
    logic take_byte;  // latch record low byte
    logic emit;       // load output register
  } frl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_clear;
    logic need_read;
    logic clear_last;
    logic want_byte;
    logic out_free;
  } frl_stat_t;

endpackage

/* rtl/flash_page_record_log_top.sv */
// ----------------------------------------------------------------------------
// flash_page_record_log_top
// Record log kept in one erasable flash page of 16-bit words.
// ----------------------------------------------------------------------------
// One command word comes in on the in_ stream (append a record byte, clear
// the last count words, clear all used words, or read a record) and exactly
// one result word goes out on the out_ stream for it.
// Items are taken one at a time. From acceptance, every item passes the decide
// step and then goes to the output register: appends, clears with nothing to
// zero and reads that fail the count checks go there straight; a read checks
// the marker of its first record and, unless that lacks the marker or the
// position is past the run, fetches its record byte; a clear zeroes its words
// one per cycle through the single write port of the page RAM.
// A new word is accepted in the cycle after the result is loaded.
// The page is never swept: words at or above the fill pointer are never read
// and count as erased, so a page erase only rewinds the fill pointer. Reset clears
// the fill pointer and run state at once; no init pass is needed.
// If the receiver stalls, the result waits in the output register; one more
// item may be accepted and worked, and its result holds until the slot frees.
// ----------------------------------------------------------------------------
module flash_page_record_log_top
  import frl_pkg::*;
#(
  parameter int PAGE_WORDS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [1:0] operation, [12:2] count, [22:13] position, [30:23] data_byte, [31] zero
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [1:0] status, [9:2] read_byte, [10] page_erased, [21:11] fill_level, [23:22] zero
  output logic [OUT_W-1:0] out_tdata
);

  frl_cmd_t  cmd;
  frl_stat_t stat;

  frl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  frl_dp #(
    .PAGE_WORDS(PAGE_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

endmodule

/* rtl/frl_ram.sv */
// ----------------------------------------------------------------------------
// frl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/frl_ctrl.sv */
// ----------------------------------------------------------------------------
// frl_ctrl
// Sequencer for the record log: decide, clear sweep, record reads, emit.
// ----------------------------------------------------------------------------
module frl_ctrl
  import frl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  frl_stat_t stat,
  output frl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECIDE  = 6'b000010,
    S_CLEAR   = 6'b000100,
    S_RDFIRST = 6'b001000,
    S_RDDATA  = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.need_clear) begin
          state_nxt = S_CLEAR;
        end else if (stat.need_read) begin
          state_nxt = S_RDFIRST;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_RDFIRST: begin
        cmd.chk_first = 1'b1;
        state_nxt     = stat.want_byte ? S_RDDATA : S_EMIT;
      end
      S_RDDATA: begin
        cmd.take_byte = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/frl_dp.sv */
// ----------------------------------------------------------------------------
// frl_dp
// Datapath: page memory, fill pointer, run state, result and output register.
// ----------------------------------------------------------------------------
module frl_dp
  import frl_pkg::*;
#(
  parameter int PAGE_WORDS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  frl_cmd_t         cmd,
  output frl_stat_t        stat,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tvalid,
  input  logic             out_tready
);

  localparam int AW = $clog2(PAGE_WORDS);
  localparam int FW = AW + 1;
  localparam int CW = (FW > CNT_W) ? FW : CNT_W;
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] PAGE_C = SW'(PAGE_WORDS);

  // captured item
  logic [OP_W-1:0]   op_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [POS_W-1:0]  pos_r;
  logic [BYTE_W-1:0] dat_r;

  // log state
  logic [FW-1:0] fp_r;
  logic [AW-1:0] base_r;
  logic          rej_r;

  logic [FW-1:0] ptr_r;
  logic [AW-1:0] first_r;

  logic [STAT_W-1:0] res_status_r;
  logic [BYTE_W-1:0] res_byte_r;
  logic              res_erased_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_erased_r;
  logic [FILL_W-1:0] out_fill_r;

  logic [WORD_W-1:0] rdata;

  logic [SW-1:0] cnt_x, pos_x, fp_x, fp_eff_x, base_x, first_x, rd_sum;
  logic          cnt_over, erase, run_start, do_start, rej_eff, app_wr;
  logic [FW-1:0] fp_eff, clr_lo;
  logic [AW-1:0] base_eff;
  logic          fp_lt_cnt, cnt_zero, is_clear, is_read, marker_ok;
  logic [STAT_W-1:0] dec_status;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [SW-1:0] fill_x;

  assign cnt_x = SW'(cnt_r);
  assign pos_x = SW'(pos_r);
  assign fp_x  = SW'(fp_r);

  // append run start and placement
  assign cnt_over  = cnt_x > PAGE_C;
  assign erase     = ((PAGE_C - fp_x) < cnt_x) || (fp_x >= PAGE_C);
  assign run_start = (op_r == OP_APPEND) && (pos_r == '0);
  assign do_start  = run_start && !cnt_over;
  assign rej_eff   = run_start ? cnt_over : rej_r;
  assign fp_eff    = (do_start && erase) ? '0 : fp_r;
  assign fp_eff_x  = SW'(fp_eff);
  assign base_eff  = do_start ? fp_eff[AW-1:0] : base_r;
  assign base_x    = SW'(base_eff);
  assign app_wr    = !rej_eff && (pos_x < cnt_x) && ((base_x + pos_x) == fp_eff_x) &&
                     (fp_eff_x < PAGE_C);

  // clear range and read checks
  assign is_clear  = (op_r == OP_CLR_LAST) || (op_r == OP_CLR_ALL);
  assign is_read   = (op_r == OP_READ);
  assign fp_lt_cnt = fp_x < cnt_x;
  assign cnt_zero  = (cnt_r == '0);
  assign first_x   = fp_x - cnt_x;
  assign clr_lo    = ((op_r == OP_CLR_ALL) || fp_lt_cnt) ? '0 : first_x[FW-1:0];
  assign rd_sum    = SW'(first_r) + pos_x;
  assign marker_ok = (rdata[WORD_W-1:BYTE_W] == REC_MARKER);

  always_comb begin
    dec_status = ST_OK;
    if (op_r == OP_APPEND) begin
      dec_status = rej_eff ? ST_OVERSIZE : ST_OK;
    end else if (is_read) begin
      if (cnt_over) begin
        dec_status = ST_OVERSIZE;
      end else if (fp_lt_cnt) begin
        dec_status = ST_TOO_FEW;
      end else if (cnt_zero) begin
        // first record sits at the fill pointer, which counts as erased
        dec_status = ST_NO_MARK;
      end
    end
  end

  assign stat.need_clear = is_clear && (clr_lo != fp_r);
  assign stat.need_read  = is_read && !cnt_over && !fp_lt_cnt && !cnt_zero;
  assign stat.clear_last = ((ptr_r + FW'(1)) == fp_r);
  assign stat.want_byte  = marker_ok && (pos_x < cnt_x);
  assign stat.out_free   = !out_valid_r || out_tready;

  // memory ports
  assign ram_we    = cmd.clr_step || (cmd.decide && (op_r == OP_APPEND) && app_wr);
  assign ram_waddr = cmd.clr_step ? ptr_r[AW-1:0] : fp_eff[AW-1:0];
  assign ram_wdata = cmd.clr_step ? '0 : {REC_MARKER, dat_r};
  assign ram_raddr = cmd.chk_first ? rd_sum[AW-1:0] : first_x[AW-1:0];

  frl_ram #(
    .WIDTH(WORD_W),
    .DEPTH(PAGE_WORDS)
  ) u_page (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_tdata[1:0];
      cnt_r <= in_tdata[12:2];
      pos_r <= in_tdata[22:13];
      dat_r <= in_tdata[30:23];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r   <= '0;
      base_r <= '0;
      rej_r  <= 1'b0;
    end else if (cmd.decide && (op_r == OP_APPEND)) begin
      rej_r  <= rej_eff;
      base_r <= base_eff;
      fp_r   <= app_wr ? (fp_eff + FW'(1)) : fp_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      ptr_r        <= clr_lo;
      first_r      <= first_x[AW-1:0];
      res_status_r <= dec_status;
      res_byte_r   <= '0;
      res_erased_r <= do_start && erase;
    end else begin
      if (cmd.clr_step) begin
        ptr_r <= ptr_r + FW'(1);
      end
      if (cmd.chk_first && !marker_ok) begin
        res_status_r <= ST_NO_MARK;
      end
      if (cmd.take_byte) begin
        res_byte_r <= rdata[BYTE_W-1:0];
      end
    end
  end

  assign fill_x = SW'(fp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_byte_r   <= res_byte_r;
      out_erased_r <= res_erased_r;
      out_fill_r   <= fill_x[FILL_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_fill_r, out_erased_r, out_byte_r, out_status_r};

endmodule

/* tb/flash_page_record_log_top_tb.sv */
// ----------------------------------------------------------------------------
// flash_page_record_log_top_tb
// Self-checking bench for the flash page record log.
// ----------------------------------------------------------------------------
// Command words go in on the in_ stream with random gaps. Each accepted word
// is fed to a scoreboard that keeps its own page image and fill pointer and
// queues the result it expects. Result words are taken with a randomly
// stalling tready, with one long hold-off, and compared field by field.
// Directed words cover the corners first, then count checks on a partly
// filled page, then random append/read runs mixed with clears, noise and
// broken runs.
// ----------------------------------------------------------------------------
module flash_page_record_log_top_tb;
  import frl_pkg::*;

  localparam int PAGE = 1024;

  // status sits in the low bits, same layout as out_tdata[21:0]
  typedef struct packed {
    logic [FILL_W-1:0] fill_level;
    logic              page_erased;
    logic [BYTE_W-1:0] read_byte;
    logic [STAT_W-1:0] status;
  } log_result_t;

  class record_log_scoreboard;
    logic [WORD_W-1:0] page [PAGE];
    int fill_ptr;
    int run_base;
    bit run_rej;
    log_result_t pending [$];
    int errors;

    function new();
      wipe_page();
      run_base = 0;
      run_rej  = 0;
      errors   = 0;
    endfunction

    function void wipe_page();
      foreach (page[i]) page[i] = '1;
      fill_ptr = 0;
    endfunction

    function void zero_range(int first, int n);
      for (int i = first; i < first + n; i++)
        if (i < PAGE) page[i] = '0;
    endfunction

    // apply one accepted command word and queue its result
    function void note_input(logic [IN_W-1:0] w);
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] dat;
      logic [WORD_W-1:0] head;
      int cnt;
      int pos;
      int first;
      log_result_t r;
      op  = w[1:0];
      cnt = w[12:2];
      pos = w[22:13];
      dat = w[30:23];
      r   = '0;
      case (op)
        OP_APPEND: begin
          if (pos == 0) begin
            if (cnt > PAGE) begin
              run_rej = 1;
            end else begin
              run_rej = 0;
              if (PAGE - fill_ptr < cnt || fill_ptr >= PAGE) begin
                wipe_page();
                r.page_erased = 1'b1;
              end
              run_base = fill_ptr;
            end
          end
          if (run_rej) begin
            r.status = ST_OVERSIZE;
          end else if (pos < cnt && run_base + pos == fill_ptr && fill_ptr < PAGE) begin
            page[fill_ptr] = {REC_MARKER, dat};
            fill_ptr++;
          end
        end
        OP_CLR_LAST: begin
          if (fill_ptr < cnt) zero_range(0, fill_ptr);
          else zero_range(fill_ptr - cnt, cnt);
        end
        OP_CLR_ALL: begin
          zero_range(0, fill_ptr);
        end
        OP_READ: begin
          if (cnt > PAGE) begin
            r.status = ST_OVERSIZE;
          end else if (fill_ptr < cnt) begin
            r.status = ST_TOO_FEW;
          end else begin
            first = fill_ptr - cnt;
            // a word past the page reads as erased
            head = (first < PAGE) ? page[first] : '1;
            if (head[15:8] != REC_MARKER) r.status = ST_NO_MARK;
            else if (pos < cnt && first + pos < PAGE) r.read_byte = page[first + pos][7:0];
          end
        end
      endcase
      r.fill_level = fill_ptr[FILL_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] w);
      log_result_t want;
      log_result_t got;
      got = w[21:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h, nothing pending", $time, w);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.read_byte != want.read_byte) begin
        $display("%0t: read_byte expected %h actual %h", $time, want.read_byte,
                 got.read_byte);
        errors++;
      end
      if (got.page_erased != want.page_erased) begin
        $display("%0t: page_erased expected %0d actual %0d", $time, want.page_erased,
                 got.page_erased);
        errors++;
      end
      if (got.fill_level != want.fill_level) begin
        $display("%0t: fill_level expected %0d actual %0d", $time, want.fill_level,
                 got.fill_level);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  record_log_scoreboard sb = new();
  bit quiet_tx;
  bit draining;
  int n_sent;

  flash_page_record_log_top #(
    .PAGE_WORDS(PAGE)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input int cnt, input int pos,
                           input int dat);
    int gap;
    gap = pick_gap(quiet_tx);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, dat[BYTE_W-1:0], pos[POS_W-1:0], cnt[CNT_W-1:0], op};
    do @(posedge clk); while (!in_tready);
    sb.note_input(in_tdata);
    n_sent++;
  endtask

  // result side: random stalls, one long hold-off, calm stretches
  initial begin : rx_side
    int stall;
    int n_rx;
    bit held;
    stall = 0;
    n_rx  = 0;
    held  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        n_rx++;
      end
      if (!held && n_rx >= 200) begin
        held  = 1;
        stall = 400;
      end else if (stall == 0 && (n_rx / 150) % 3 != 2) begin
        stall = pick_gap(1'b0);
      end
      if (draining) stall = 0;
      out_tready <= (stall == 0);
      if (stall > 0) stall--;
    end
  end

  initial begin : stimulus
    int cnt;
    int pos;
    int n;
    int p;
    int k;
    int kind;
    int rand_base;
    bit broken;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    quiet_tx  = 0;
    draining  = 0;
    n_sent    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_word(OP_APPEND,   5,    1,    8'h11);  // append before any run
    send_word(OP_READ,     0,    0,    8'h00);  // count zero: marker missing
    send_word(OP_READ,     2047, 0,    8'h00);
    send_word(OP_READ,     1,    0,    8'h00);  // empty page: too few
    send_word(OP_APPEND,   2047, 0,    8'h22);  // rejected run
    send_word(OP_APPEND,   2047, 1,    8'h33);
    send_word(OP_APPEND,   3,    0,    8'h00);
    send_word(OP_APPEND,   3,    1,    8'hFF);
    send_word(OP_APPEND,   3,    2,    8'hA5);
    send_word(OP_APPEND,   3,    3,    8'h44);  // past run end
    send_word(OP_READ,     3,    0,    8'hFF);
    send_word(OP_READ,     3,    1,    8'h00);
    send_word(OP_READ,     3,    2,    8'h00);
    send_word(OP_READ,     3,    1023, 8'h00);  // read past run
    send_word(OP_CLR_LAST, 1,    1023, 8'hFF);
    send_word(OP_READ,     1,    0,    8'h00);
    send_word(OP_READ,     2,    0,    8'h00);
    send_word(OP_CLR_LAST, 2047, 0,    8'h00);  // more than used
    send_word(OP_APPEND,   PAGE, 0,    8'h5A);  // does not fit: erase
    send_word(OP_APPEND,   PAGE, 1,    8'hC3);
    send_word(OP_CLR_ALL,  0,    511,  8'hAA);
    send_word(OP_APPEND,   0,    0,    8'h55);
    send_word(OP_READ,     2,    1,    8'h00);
    send_word(OP_APPEND,   1,    0,    8'h3C);
    send_word(OP_READ,     1,    0,    8'h00);

    // count checks on a partly filled page
    send_word(OP_READ,     PAGE,     0,        8'h00);
    send_word(OP_READ,     PAGE,     PAGE - 1, 8'h00);
    send_word(OP_READ,     PAGE + 1, 0,        8'h00);
    send_word(OP_READ,     1,        0,        8'h00);
    send_word(OP_CLR_LAST, PAGE,     0,        8'h00);
    send_word(OP_READ,     PAGE,     3,        8'h00);
    send_word(OP_APPEND,   0,        0,        8'h00);
    send_word(OP_APPEND,   PAGE,     5,        8'h00);

    // random runs
    rand_base = n_sent;
    while (n_sent - rand_base < 570) begin
      quiet_tx = ((n_sent - rand_base) / 100) % 4 == 3;
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        k = $urandom_range(0, 99);
        if (k < 80) cnt = $urandom_range(1, 12);
        else if (k < 90) cnt = $urandom_range(13, 80);
        else if (k < 95) cnt = 0;
        else cnt = $urandom_range(PAGE + 1, 2047);
        broken = ($urandom_range(0, 6) == 0);
        n = (cnt == 0) ? 1 : (cnt > PAGE) ? $urandom_range(1, 3) : cnt;
        for (p = 0; p < n; p++) begin
          pos = p;
          if (broken && p > 0 && $urandom_range(0, 3) == 0) pos = $urandom_range(0, PAGE - 1);
          send_word(OP_APPEND, cnt, pos, $urandom_range(0, 255));
        end
        if (broken && $urandom_range(0, 1) == 1)
          send_word(OP_APPEND, cnt, n, $urandom_range(0, 255));
      end else if (kind < 75) begin
        k = $urandom_range(0, 99);
        if (k < 75 && sb.fill_ptr > 0)
          cnt = $urandom_range(1, (sb.fill_ptr < 12) ? sb.fill_ptr : 12);
        else if (k < 95) cnt = $urandom_range(0, PAGE);
        else cnt = $urandom_range(PAGE + 1, 2047);
        n = (cnt == 0 || cnt > 16) ? $urandom_range(1, 3) : cnt;
        for (p = 0; p < n; p++)
          send_word(OP_READ, cnt, (cnt > 16) ? $urandom_range(0, cnt - 1) : p,
                    $urandom_range(0, 255));
        if (cnt < PAGE && $urandom_range(0, 9) == 0)
          send_word(OP_READ, cnt, $urandom_range(cnt, PAGE - 1), $urandom_range(0, 255));
      end else if (kind < 85) begin
        // noise word, any op and any fields
        send_word(OP_W'($urandom_range(0, 3)), $urandom_range(0, 2047),
                  $urandom_range(0, PAGE - 1), $urandom_range(0, 255));
      end else if (kind < 93) begin
        cnt = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : $urandom_range(0, 2047);
        send_word(OP_CLR_LAST, cnt, $urandom_range(0, PAGE - 1), $urandom_range(0, 255));
      end else begin
        send_word(OP_CLR_ALL, $urandom_range(0, 2047), $urandom_range(0, PAGE - 1),
                  $urandom_range(0, 255));
      end
    end

    in_tvalid <= 1'b0;
    draining = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("%0t: timeout, %0d results still pending", $time, sb.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
